// ===== hdl/bilinear_warp_blend_dither_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the blend block.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_WARP_BLEND_DITHER_TOP_MACROS_SVH
`define BILINEAR_WARP_BLEND_DITHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BWBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bwbd checker: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BWBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bwbd checker: next-cycle property failed");

`endif

// ===== hdl/bwbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bwbd_pkg
// Widths, payload types and the per-channel blend function of the block.
// ----------------------------------------------------------------------------
package bwbd_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int SUM_W   = 2 * CHAN_W;
   localparam int NUM_TAP = 4;

   typedef logic [NUM_TAP-1:0][PIX_W-1:0]  pix_quad_type;
   typedef logic [NUM_TAP-1:0][CHAN_W-1:0] byte_quad_type;

   // Weighted sum of one channel of the four taps plus the carried error,
   // wrapped to the sum width.
   function automatic logic [SUM_W-1:0] blend_sum(input byte_quad_type chan,
                                                  input byte_quad_type wgt,
                                                  input logic [CHAN_W-1:0] err);
      logic [SUM_W-1:0] acc;
      acc = {{(SUM_W-CHAN_W){1'b0}}, err};
      for (int i = 0; i < NUM_TAP; i++) begin
         acc = acc + (SUM_W'(chan[i]) * SUM_W'(wgt[i]));
      end
      return acc;
   endfunction

endpackage

// ===== hdl/bilinear_warp_blend_dither_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_warp_blend_dither_top
// Four-tap bilinear pixel blend with per-channel error diffusion.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries four neighboring 24-bit pixels (blue 7:0,
//   green 15:8, red 23:16), four 8-bit weights in 1/256 units and a
//   frame start flag. The response channel returns one blended pixel as
//   blue, green and red bytes for every request, in order.
//   Each channel keeps an 8-bit carried error: the low byte of the last
//   wrapped sum is added into the next pixel's sum. Frame start makes the
//   pixel use zero errors; its own errors are kept for the next pixel.
//   A request transfer loads the input register; the blend logic then
//   feeds the result register, whose valid flag drives the response.
//   Throughput is one pixel per cycle unless the receiver stalls;
//   the error feedback loop closes within the single blend stage.
//   When the receiver stalls, the result register holds, the input
//   register still takes one more request, and then req_ready drops.
//   Reset clears both valid flags and all carried errors.
// ----------------------------------------------------------------------------
module bilinear_warp_blend_dither_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bwbd_pkg::PIX_W-1:0] req_pixel_top_left,
   input  logic [bwbd_pkg::PIX_W-1:0] req_pixel_top_right,
   input  logic [bwbd_pkg::PIX_W-1:0] req_pixel_bottom_left,
   input  logic [bwbd_pkg::PIX_W-1:0] req_pixel_bottom_right,
   input  logic [bwbd_pkg::CHAN_W-1:0] req_weight_top_left,
   input  logic [bwbd_pkg::CHAN_W-1:0] req_weight_top_right,
   input  logic [bwbd_pkg::CHAN_W-1:0] req_weight_bottom_left,
   input  logic [bwbd_pkg::CHAN_W-1:0] req_weight_bottom_right,
   input  logic                       req_frame_start,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bwbd_pkg::CHAN_W-1:0] rsp_blue_out,
   output logic [bwbd_pkg::CHAN_W-1:0] rsp_green_out,
   output logic [bwbd_pkg::CHAN_W-1:0] rsp_red_out
);
   import bwbd_pkg::*;

   logic          in_valid_ff;
   pix_quad_type  pix_ff;
   byte_quad_type wgt_ff;
   logic          frame_start_ff;

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] blue_ff, green_ff, red_ff;
   logic [CHAN_W-1:0] blue_err_ff, green_err_ff, red_err_ff;

   logic              advance;
   logic              take_req;
   logic              rsp_valid_in;
   logic              in_valid_in;
   byte_quad_type     blue_chan, green_chan, red_chan;
   logic [CHAN_W-1:0] blue_err_use, green_err_use, red_err_use;
   logic [SUM_W-1:0]  blue_sum, green_sum, red_sum;

   // The result register can load whenever it is empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < NUM_TAP; i++) begin
         blue_chan[i]  = pix_ff[i][CHAN_W-1:0];
         green_chan[i] = pix_ff[i][2*CHAN_W-1:CHAN_W];
         red_chan[i]   = pix_ff[i][3*CHAN_W-1:2*CHAN_W];
      end
      blue_err_use  = frame_start_ff ? '0 : blue_err_ff;
      green_err_use = frame_start_ff ? '0 : green_err_ff;
      red_err_use   = frame_start_ff ? '0 : red_err_ff;
      blue_sum  = blend_sum(blue_chan, wgt_ff, blue_err_use);
      green_sum = blend_sum(green_chan, wgt_ff, green_err_use);
      red_sum   = blend_sum(red_chan, wgt_ff, red_err_use);
   end

   always_comb begin
      in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blue_err_ff  <= '0;
         green_err_ff <= '0;
         red_err_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Errors move only when a pixel passes into the result register.
         if (advance && in_valid_ff) begin
            blue_err_ff  <= blue_sum[CHAN_W-1:0];
            green_err_ff <= green_sum[CHAN_W-1:0];
            red_err_ff   <= red_sum[CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         pix_ff[0]      <= req_pixel_top_left;
         pix_ff[1]      <= req_pixel_top_right;
         pix_ff[2]      <= req_pixel_bottom_left;
         pix_ff[3]      <= req_pixel_bottom_right;
         wgt_ff[0]      <= req_weight_top_left;
         wgt_ff[1]      <= req_weight_top_right;
         wgt_ff[2]      <= req_weight_bottom_left;
         wgt_ff[3]      <= req_weight_bottom_right;
         frame_start_ff <= req_frame_start;
      end
      if (advance && in_valid_ff) begin
         blue_ff  <= blue_sum[SUM_W-1:CHAN_W];
         green_ff <= green_sum[SUM_W-1:CHAN_W];
         red_ff   <= red_sum[SUM_W-1:CHAN_W];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;

endmodule

// ===== hdl/bwbd_checker.sv =====
// ----------------------------------------------------------------------------
// bwbd_checker
// Port-level properties of the blend block, bound to its top level.
// ----------------------------------------------------------------------------
`include "bilinear_warp_blend_dither_top_macros.svh"

module bwbd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [bwbd_pkg::CHAN_W-1:0] req_weight_top_left,
   input logic [bwbd_pkg::CHAN_W-1:0] req_weight_top_right,
   input logic [bwbd_pkg::CHAN_W-1:0] req_weight_bottom_left,
   input logic [bwbd_pkg::CHAN_W-1:0] req_weight_bottom_right,
   input logic                        req_frame_start,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bwbd_pkg::CHAN_W-1:0] rsp_blue_out,
   input logic [bwbd_pkg::CHAN_W-1:0] rsp_green_out,
   input logic [bwbd_pkg::CHAN_W-1:0] rsp_red_out
);
   import bwbd_pkg::*;

   logic req_xfer;
   logic zero_req;

   assign req_xfer = req_valid && req_ready;
   assign zero_req = req_xfer && req_frame_start
                     && (req_weight_top_left == '0) && (req_weight_top_right == '0)
                     && (req_weight_bottom_left == '0) && (req_weight_bottom_right == '0);

   // A stalled response keeps its valid and its pixel.
   `BWBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_blue_out) && $stable(rsp_green_out) && $stable(rsp_red_out))

   // Requests are refused only while both stages are full and the output is stalled.
   `BWBD_ASSERT_NOW(a_ready_low_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // A transfer followed by an open receiver yields a valid response.
   `BWBD_ASSERT_NEXT(a_latency, clock, reset, req_xfer ##1 rsp_ready, rsp_valid)

   // A frame start pixel with all weights zero blends to black.
   `BWBD_ASSERT_NEXT(a_zero_blend, clock, reset, zero_req ##1 rsp_ready,
      rsp_valid && (rsp_blue_out == '0) && (rsp_green_out == '0) && (rsp_red_out == '0))

endmodule

bind bilinear_warp_blend_dither_top bwbd_checker u_bwbd_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_ready               (req_ready),
   .req_weight_top_left     (req_weight_top_left),
   .req_weight_top_right    (req_weight_top_right),
   .req_weight_bottom_left  (req_weight_bottom_left),
   .req_weight_bottom_right (req_weight_bottom_right),
   .req_frame_start         (req_frame_start),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_blue_out            (rsp_blue_out),
   .rsp_green_out           (rsp_green_out),
   .rsp_red_out             (rsp_red_out)
);

// ===== bench/bilinear_warp_blend_dither_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_warp_blend_dither_top_tb
// Drives four-tap pixel blends through the request channel and checks every
// blended pixel against a cycle-free predictor of the weighted sums and the
// per-channel carried errors, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module bilinear_warp_blend_dither_top_tb;

   import bwbd_pkg::*;

   localparam int TAP_TL = 0;
   localparam int TAP_TR = 1;
   localparam int TAP_BL = 2;
   localparam int TAP_BR = 3;

   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;
   localparam int NUM_CH   = 3;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      pix_quad_type  pix;
      byte_quad_type wgt;
      logic          frame_start;
   } pixel_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [PIX_W-1:0]  req_pixel_top_left = '0;
   logic [PIX_W-1:0]  req_pixel_top_right = '0;
   logic [PIX_W-1:0]  req_pixel_bottom_left = '0;
   logic [PIX_W-1:0]  req_pixel_bottom_right = '0;
   logic [CHAN_W-1:0] req_weight_top_left = '0;
   logic [CHAN_W-1:0] req_weight_top_right = '0;
   logic [CHAN_W-1:0] req_weight_bottom_left = '0;
   logic [CHAN_W-1:0] req_weight_bottom_right = '0;
   logic              req_frame_start = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_blue_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_red_out;

   // Predictor state: the error carried from one pixel to the next per channel.
   logic [CHAN_W-1:0] carried_err [NUM_CH];

   pixel_rsp_type exp_pixels [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_request = 0;
   int hold_off_left = 0;
   int frame_left = 0;

   bilinear_warp_blend_dither_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_pixel_top_left      (req_pixel_top_left),
      .req_pixel_top_right     (req_pixel_top_right),
      .req_pixel_bottom_left   (req_pixel_bottom_left),
      .req_pixel_bottom_right  (req_pixel_bottom_right),
      .req_weight_top_left     (req_weight_top_left),
      .req_weight_top_right    (req_weight_top_right),
      .req_weight_bottom_left  (req_weight_bottom_left),
      .req_weight_bottom_right (req_weight_bottom_right),
      .req_frame_start         (req_frame_start),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_blue_out            (rsp_blue_out),
      .rsp_green_out           (rsp_green_out),
      .rsp_red_out             (rsp_red_out)
   );

   always #2 clock = ~clock;

   // Blends one pixel and advances the carried errors, as the block does.
   function automatic pixel_rsp_type blend_pixel(input pixel_req_type r);
      logic [SUM_W-1:0]  acc;
      logic [CHAN_W-1:0] chan_out [NUM_CH];
      pixel_rsp_type     res;
      if (r.frame_start) begin
         for (int ch = 0; ch < NUM_CH; ch++) carried_err[ch] = '0;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         acc = SUM_W'(carried_err[ch]);
         for (int tap = 0; tap < NUM_TAP; tap++) begin
            acc = acc + SUM_W'(r.pix[tap][ch*CHAN_W +: CHAN_W]) * SUM_W'(r.wgt[tap]);
         end
         carried_err[ch] = acc[CHAN_W-1:0];
         chan_out[ch] = acc[SUM_W-1:CHAN_W];
      end
      res.blue  = chan_out[CH_BLUE];
      res.green = chan_out[CH_GREEN];
      res.red   = chan_out[CH_RED];
      return res;
   endfunction

   function automatic pixel_req_type make_req(input logic [PIX_W-1:0] tl, tr, bl, br,
                                              input logic [CHAN_W-1:0] wtl, wtr, wbl, wbr,
                                              input logic fs);
      pixel_req_type r;
      r.pix[TAP_TL] = tl;
      r.pix[TAP_TR] = tr;
      r.pix[TAP_BL] = bl;
      r.pix[TAP_BR] = br;
      r.wgt[TAP_TL] = wtl;
      r.wgt[TAP_TR] = wtr;
      r.wgt[TAP_BL] = wbl;
      r.wgt[TAP_BR] = wbr;
      r.frame_start = fs;
      return r;
   endfunction

   // Offers one pixel after a random gap and returns at the edge of its transfer,
   // with valid still high so that back-to-back transfers stay possible.
   task automatic send_pixel(input pixel_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_pixel_top_left      <= r.pix[TAP_TL];
      req_pixel_top_right     <= r.pix[TAP_TR];
      req_pixel_bottom_left   <= r.pix[TAP_BL];
      req_pixel_bottom_right  <= r.pix[TAP_BR];
      req_weight_top_left     <= r.wgt[TAP_TL];
      req_weight_top_right    <= r.wgt[TAP_TR];
      req_weight_bottom_left  <= r.wgt[TAP_BL];
      req_weight_bottom_right <= r.wgt[TAP_BR];
      req_frame_start         <= r.frame_start;
      req_valid               <= 1'b1;
      do @(posedge clock); while (!req_ready);
      exp_pixels.push_back(blend_pixel(r));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (exp_pixels.size() != 0) @(posedge clock);
   endtask

   // Pixel streams are mostly frames that open with a frame start; now and then
   // a stray frame start lands in the middle of one.
   task automatic make_random_req(output pixel_req_type r);
      int fx;
      int fy;
      int w [NUM_TAP];
      for (int tap = 0; tap < NUM_TAP; tap++) begin
         case ($urandom_range(0, 9))
            0: r.pix[tap] = '0;
            1: r.pix[tap] = '1;
            default: r.pix[tap] = PIX_W'($urandom);
         endcase
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            fx = $urandom_range(0, 255);
            fy = $urandom_range(0, 255);
            w[TAP_TL] = ((256 - fx) * (256 - fy)) >> 8;
            w[TAP_TR] = (fx * (256 - fy)) >> 8;
            w[TAP_BL] = ((256 - fx) * fy) >> 8;
            w[TAP_BR] = (fx * fy) >> 8;
         end
         8: for (int tap = 0; tap < NUM_TAP; tap++) w[tap] = 255;
         9: for (int tap = 0; tap < NUM_TAP; tap++) begin
            w[tap] = $urandom_range(0, 1) ? $urandom_range(0, 255) : 0;
         end
         default: for (int tap = 0; tap < NUM_TAP; tap++) w[tap] = $urandom_range(0, 255);
      endcase
      for (int tap = 0; tap < NUM_TAP; tap++) r.wgt[tap] = CHAN_W'((w[tap] > 255) ? 255 : w[tap]);
      if (frame_left == 0) begin
         frame_left = $urandom_range(1, 40);
         r.frame_start = 1'b1;
      end else begin
         r.frame_start = ($urandom_range(0, 39) == 0);
      end
      frame_left--;
   endtask

   task automatic test_blend_extremes();
      send_pixel(make_req('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
      // Weights well above a sum of 256 make every channel sum wrap.
      send_pixel(make_req('1, '1, '1, '1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(make_req('1, '1, '1, '1, 8'd64, 8'd64, 8'd64, 8'd64, 1'b1));
      send_pixel(make_req(24'h123456, 24'hABCDEF, 24'h0F1E2D, 24'hF0E1D2,
                          8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
      send_pixel(make_req(24'h123456, 24'hABCDEF, 24'h0F1E2D, 24'hF0E1D2,
                          8'h00, 8'hFF, 8'h00, 8'h00, 1'b0));
      send_pixel(make_req(24'h123456, 24'hABCDEF, 24'h0F1E2D, 24'hF0E1D2,
                          8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
      send_pixel(make_req(24'h123456, 24'hABCDEF, 24'h0F1E2D, 24'hF0E1D2,
                          8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
      send_pixel(make_req(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                          8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0));
      send_pixel(make_req(24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE,
                          8'd200, 8'd200, 8'd200, 8'd200, 1'b0));
      send_pixel(make_req('0, '0, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
   endtask

   // Pixel values with weights that sum to 256 leave an error to carry from pixel to pixel,
   // so the frame start in the middle shows whether the errors get dropped.
   task automatic test_error_diffusion();
      for (int i = 0; i < 12; i++) begin
         send_pixel(make_req(24'h01FF7F + PIX_W'(i * 24'h030507), 24'h13579B,
                             24'h2468AC, 24'hFDB975,
                             8'd77, 8'd51, 8'd89, 8'd39, (i == 6)));
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      pixel_req_type r;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         make_random_req(r);
         send_pixel(r);
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_hold_off();
      pixel_req_type r;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_request = 80;
      for (int i = 0; i < 16; i++) begin
         make_random_req(r);
         send_pixel(r);
      end
   endtask

   task automatic test_pause_until_drained();
      pixel_req_type r;
      send_idle_pct = 25;
      recv_stall_pct = 25;
      wait_all_results();
      for (int i = 0; i < 16; i++) begin
         make_random_req(r);
         send_pixel(r);
      end
   endtask

   task automatic check_pixel_result();
      pixel_rsp_type want;
      if (exp_pixels.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected pixel result: blue %02h green %02h red %02h",
                     rsp_blue_out, rsp_green_out, rsp_red_out);
         end
      end else begin
         want = exp_pixels.pop_front();
         if (rsp_blue_out !== want.blue || rsp_green_out !== want.green ||
             rsp_red_out !== want.red) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("pixel result wrong: expected %02h %02h %02h, got %02h %02h %02h",
                        want.blue, want.green, want.red,
                        rsp_blue_out, rsp_green_out, rsp_red_out);
            end
         end
      end
   endtask

   // Result side: checks each transfer and picks the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_pixel_result();
      if (hold_off_request > 0) begin
         hold_off_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bilinear_warp_blend_dither_top: mismatch");
         $finish;
      end
   end

   initial begin
      for (int ch = 0; ch < NUM_CH; ch++) carried_err[ch] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_blend_extremes();
      test_error_diffusion();
      test_random_traffic(175, 0, 0);
      test_random_traffic(175, 78, 0);
      test_output_hold_off();
      test_random_traffic(175, 0, 78);
      test_pause_until_drained();
      test_random_traffic(175, 25, 25);
      wait_all_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && exp_pixels.size() == 0) begin
         $display("bilinear_warp_blend_dither_top: match");
      end else begin
         $display("bilinear_warp_blend_dither_top: mismatch");
      end
      $finish;
   end

endmodule
